// ----- design/olir_pkg.sv -----
// ---------------------------------------------------------------------------
// olir_pkg: shared definitions for the ordered list
// Operation codes, field widths and the control bundle sent to the cells.
// ---------------------------------------------------------------------------
package olir_pkg;

   localparam int DATA_W        = 32;
   localparam int OP_W          = 2;
   localparam int COUNT_FIELD_W = 5;
   localparam int DEFAULT_DEPTH = 16;

   localparam logic [OP_W-1:0] OP_ADD_FRONT = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD_BACK  = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE    = 2'd2;
   localparam logic [OP_W-1:0] OP_NOP       = 2'd3;

   // broadcast to every cell of the row
   typedef struct packed {
      logic            capture;  // latch per-cell compare against the incoming value
      logic            upd;      // apply the operation this cycle
      logic [OP_W-1:0] op;
      logic            full;
   } ctl_type;

endpackage

// ----- design/olir_req_if.sv -----
// ---------------------------------------------------------------------------
// olir_req_if: request channel
// Valid/ready channel carrying one operation and its value per beat.
// ---------------------------------------------------------------------------
interface olir_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         op;
   logic signed [31:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

// ----- design/olir_rsp_if.sv -----
// ---------------------------------------------------------------------------
// olir_rsp_if: response channel
// Valid/ready channel carrying the list summary after each operation.
// ---------------------------------------------------------------------------
interface olir_rsp_if;
   logic               valid;
   logic               ready;
   logic [4:0]         count;
   logic               is_empty;
   logic signed [31:0] head_value;
   logic signed [31:0] tail_value;
   logic               removed;
   logic               dropped;

   modport source (output valid, output count, output is_empty, output head_value,
                   output tail_value, output removed, output dropped, input ready);
   modport sink   (input valid, input count, input is_empty, input head_value,
                   input tail_value, input removed, input dropped, output ready);
endinterface

// ----- design/ordered_list_insert_remove_top.sv -----
// ---------------------------------------------------------------------------
// ordered_list_insert_remove_top: deque with remove-by-value
// Row of DEPTH cells holding the list front first; adds at either end and
// removes the first entry equal to a given value.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one operation per beat: add at front, add at back, or
//   remove the first equal entry (op code 3 does nothing). rsp_bus returns
//   exactly one beat per request with count, empty flag, head and tail
//   values (0 when empty), and removed / dropped flags.
//   Sequence: the request beat latches per-cell compares, the update state
//   shifts the cell row and updates the count, and the result state loads
//   the response register once it is free.
//   Overlap: no new request is taken during the compare-then-shift pass
//   through the cell row; the next request is taken in the same cycle the
//   previous response is loaded.
//   Stall: if rsp_bus is held not ready, the finished summary waits in the
//   response register, one more result waits for it in the result state,
//   and req_bus.ready stays low until the response register frees.
//   Reset: synchronous; the list comes up empty, no response pending.
//   Adds to a full list are refused and flagged in dropped.
// ---------------------------------------------------------------------------
module ordered_list_insert_remove_top #(
   parameter int DEPTH = olir_pkg::DEFAULT_DEPTH
) (
   input logic     clock,
   input logic     reset,
   olir_req_if.sink   req_bus,
   olir_rsp_if.source rsp_bus
);
   import olir_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_RESULT = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              removed_ff, removed_in;
   logic              dropped_ff, dropped_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [COUNT_FIELD_W-1:0] rsp_count_ff, rsp_count_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic [DATA_W-1:0] rsp_head_ff, rsp_head_in;
   logic [DATA_W-1:0] rsp_tail_ff, rsp_tail_in;
   logic              rsp_removed_ff, rsp_removed_in;
   logic              rsp_dropped_ff, rsp_dropped_in;

   logic              accept;
   logic              load;
   logic              full;
   logic              any_hit;
   ctl_type           ctl;

   logic [DATA_W-1:0] cell_data [DEPTH];
   logic [DATA_W-1:0] cell_tail [DEPTH];
   logic [DEPTH-1:0]  hit_vec;
   logic [DEPTH-1:0]  after_vec;
   logic [DATA_W-1:0] tail_sel;

   assign full    = count_ff == CW'(DEPTH);
   assign any_hit = |hit_vec;
   assign load    = (state_ff == ST_RESULT) && (!rsp_valid_ff || rsp_bus.ready);

   assign req_bus.ready = (state_ff == ST_IDLE) || load;
   assign accept        = req_bus.valid && req_bus.ready;

   assign ctl.capture = accept;
   assign ctl.upd     = state_ff == ST_UPDATE;
   assign ctl.op      = op_ff;
   assign ctl.full    = full;

   // inclusive prefix OR: bit i set when some cell at or before i matched
   always_comb begin
      after_vec = hit_vec;
      for (int s = 1; s < DEPTH; s = s * 2) begin
         after_vec = after_vec | (after_vec << s);
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data, right_data;
      if (i == 0) begin : g_first
         assign left_data = value_ff;
      end else begin : g_mid
         assign left_data = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_data = cell_data[i];
      end else begin : g_inner
         assign right_data = cell_data[i+1];
      end

      olir_cell #(.DEPTH(DEPTH), .INDEX(i)) u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .count      (count_ff),
         .cmp_value  (req_bus.value),
         .ins_value  (value_ff),
         .left_data  (left_data),
         .right_data (right_data),
         .after_hit  (after_vec[i]),
         .data       (cell_data[i]),
         .hit        (hit_vec[i]),
         .tail_term  (cell_tail[i])
      );
   end

   always_comb begin
      tail_sel = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_sel = tail_sel | cell_tail[i];
      end
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      removed_in = removed_ff;
      dropped_in = dropped_ff;
      if (accept) begin
         op_in    = req_bus.op;
         value_in = req_bus.value;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            state_in   = ST_RESULT;
            removed_in = 1'b0;
            dropped_in = 1'b0;
            unique case (op_ff)
               OP_ADD_FRONT, OP_ADD_BACK: begin
                  if (full) dropped_in = 1'b1;
                  else      count_in   = count_ff + 1'b1;
               end
               OP_REMOVE: begin
                  if (any_hit) begin
                     removed_in = 1'b1;
                     count_in   = count_ff - 1'b1;
                  end
               end
               default: ;
            endcase
         end
         ST_RESULT: begin
            if (load) state_in = accept ? ST_UPDATE : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_empty_in   = rsp_empty_ff;
      rsp_head_in    = rsp_head_ff;
      rsp_tail_in    = rsp_tail_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_dropped_in = rsp_dropped_ff;
      if (load) begin
         rsp_valid_in   = 1'b1;
         rsp_count_in   = COUNT_FIELD_W'(count_ff);
         rsp_empty_in   = count_ff == '0;
         rsp_head_in    = (count_ff == '0) ? '0 : cell_data[0];
         rsp_tail_in    = tail_sel;
         rsp_removed_in = removed_ff;
         rsp_dropped_in = dropped_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      value_ff       <= value_in;
      removed_ff     <= removed_in;
      dropped_ff     <= dropped_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_empty_ff   <= rsp_empty_in;
      rsp_head_ff    <= rsp_head_in;
      rsp_tail_ff    <= rsp_tail_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.count      = rsp_count_ff;
   assign rsp_bus.is_empty   = rsp_empty_ff;
   assign rsp_bus.head_value = rsp_head_ff;
   assign rsp_bus.tail_value = rsp_tail_ff;
   assign rsp_bus.removed    = rsp_removed_ff;
   assign rsp_bus.dropped    = rsp_dropped_ff;

   a_no_accept_in_update: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |-> !req_bus.ready)
      else $error("request taken while cell row is shifting");

   a_accept_starts_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_UPDATE))
      else $error("accepted beat did not start an update");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_removed_ff && rsp_dropped_ff))
      else $error("removed and dropped both set");

   a_update_loads_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) |=> (state_ff == ST_RESULT))
      else $error("update not followed by result stage");

endmodule

// ----- design/olir_cell.sv -----
// ---------------------------------------------------------------------------
// olir_cell: one list slot
// Holds one entry, compares it against the incoming value and shifts
// left or right with its neighbors.
// ---------------------------------------------------------------------------
module olir_cell #(
   parameter int DEPTH = olir_pkg::DEFAULT_DEPTH,
   parameter int INDEX = 0
) (
   input  logic                            clock,
   input  olir_pkg::ctl_type               ctl,
   input  logic [$clog2(DEPTH+1)-1:0]      count,
   input  logic [olir_pkg::DATA_W-1:0]     cmp_value,
   input  logic [olir_pkg::DATA_W-1:0]     ins_value,
   input  logic [olir_pkg::DATA_W-1:0]     left_data,
   input  logic [olir_pkg::DATA_W-1:0]     right_data,
   input  logic                            after_hit,
   output logic [olir_pkg::DATA_W-1:0]     data,
   output logic                            hit,
   output logic [olir_pkg::DATA_W-1:0]     tail_term
);
   import olir_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   logic [DATA_W-1:0] data_ff, data_in;
   logic              hit_ff, hit_in;
   logic              occupied;
   logic              is_tail;

   assign occupied = CW'(INDEX) < count;
   assign is_tail  = CW'(INDEX + 1) == count;

   assign hit_in = ctl.capture ? (occupied && data_ff == cmp_value) : hit_ff;

   always_comb begin
      data_in = data_ff;
      if (ctl.upd) begin
         unique case (ctl.op)
            OP_ADD_FRONT: begin
               if (!ctl.full) begin
                  data_in = (INDEX == 0) ? ins_value : left_data;
               end
            end
            OP_ADD_BACK: begin
               if (!ctl.full && count == CW'(INDEX)) begin
                  data_in = ins_value;
               end
            end
            OP_REMOVE: begin
               // everything from the first match on closes up by one
               if (after_hit) begin
                  data_in = right_data;
               end
            end
            default: data_in = data_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      hit_ff  <= hit_in;
   end

   assign data      = data_ff;
   assign hit       = hit_ff;
   assign tail_term = is_tail ? data_ff : '0;

endmodule
